// ===== rtl/bbcp_pkg.sv =====
// Shared constants, types and state codes of the bigram bit context trainer.
`default_nettype none
package bbcp_pkg;

  localparam int CountWidth    = 32;
  localparam int ProbScaleBits = 12;
  localparam int ProbWidth     = 12;
  localparam int ByteWidth     = 8;
  localparam int CtxAddrWidth  = 2 * ByteWidth;
  localparam int CtxDepth      = 1 << CtxAddrWidth;
  localparam int RamWidth      = 2 * CountWidth;
  localparam int DivWidth      = CountWidth + 2;
  localparam int BitCntWidth   = $clog2(ByteWidth);
  localparam int DivCntWidth   = $clog2(ProbScaleBits);

  localparam logic [ProbScaleBits-1:0] ProbHalf =
    ProbScaleBits'(1) << (ProbScaleBits - 1);
  localparam logic [ProbScaleBits-1:0] ProbMin = ProbScaleBits'(1);

  typedef enum logic {
    ACT_LEARN,
    ACT_QUERY
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LRD,
    ST_LWR,
    ST_QRD,
    ST_QEVAL,
    ST_QDIV,
    ST_QOUT
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [CountWidth:0]   dividend;
    logic [DivWidth-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [ProbScaleBits-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bbcp_in_if.sv =====
// Input channel: learn bytes and context queries.
`default_nettype none
interface bbcp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [bbcp_pkg::ByteWidth-1:0] data_byte;
  logic [bbcp_pkg::ByteWidth-1:0] query_prev;
  logic [bbcp_pkg::ByteWidth-1:0] query_prefix;

  modport source (output valid, action, data_byte, query_prev, query_prefix, input ready);
  modport sink   (input valid, action, data_byte, query_prev, query_prefix, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbcp_out_if.sv =====
// Output channel: smoothed probability results.
`default_nettype none
interface bbcp_out_if;
  logic                           valid;
  logic                           ready;
  logic [bbcp_pkg::ProbWidth-1:0] probability;

  modport source (output valid, probability, input ready);
  modport sink   (input valid, probability, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbcp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/bbcp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the probability estimate.
`default_nettype none
module bbcp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bbcp_pkg::div_req_t req_i,
  output bbcp_pkg::div_rsp_t      rsp_o
);

  logic [bbcp_pkg::DivWidth-1:0]      rem_q, rem_d;
  logic [bbcp_pkg::DivWidth-1:0]      div_q, div_d;
  logic [bbcp_pkg::ProbScaleBits-1:0] quo_q, quo_d;
  logic [bbcp_pkg::DivCntWidth-1:0]   cnt_q, cnt_d;
  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [bbcp_pkg::DivWidth-1:0]      shifted;
  logic [bbcp_pkg::DivWidth:0]        diff;
  logic                               qbit;

  always_comb begin
    shifted = {rem_q[bbcp_pkg::DivWidth-2:0], 1'b0};
    diff    = {1'b0, shifted} - {1'b0, div_q};
    qbit    = ~diff[bbcp_pkg::DivWidth];

    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (req_i.start) begin
      rem_d  = bbcp_pkg::DivWidth'(req_i.dividend);
      div_d  = req_i.divisor;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? diff[bbcp_pkg::DivWidth-1:0] : shifted;
      quo_d = {quo_q[bbcp_pkg::ProbScaleBits-2:0], qbit};
      cnt_d = cnt_q + bbcp_pkg::DivCntWidth'(1);
      if (cnt_q == bbcp_pkg::DivCntWidth'(bbcp_pkg::ProbScaleBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/bigram_bit_context_prior_trainer_unit.sv =====
// Top level: order-1 bitwise context counters with a smoothed probability query.
// Learn: per bit a counter read (ST_LRD) and write (ST_LWR), all eight bits; not ready
// meanwhile. Query: RAM read (ST_QRD), evaluation (ST_QEVAL), the 12-step divider and
// its done register (ST_QDIV), then ST_QOUT; a zero prefix or unseen context skips it.
// One item at a time: the next transaction is accepted only back in ST_IDLE.
// Reset: a clearing pass writes all 65536 counter entries, one per cycle, before the
// first item is accepted; the previous byte resets to zero.
`default_nettype none
module bigram_bit_context_prior_trainer_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bbcp_in_if.sink     in_i,
  bbcp_out_if.source  out_o
);

  localparam int CW = bbcp_pkg::CountWidth;
  localparam int BW = bbcp_pkg::ByteWidth;

  bbcp_pkg::state_e                      state_q, state_d;
  logic [bbcp_pkg::CtxAddrWidth-1:0]     clr_q, clr_d;
  logic [BW-1:0]                         last_q, last_d;
  logic [BW-1:0]                         byte_q, byte_d;
  logic [BW-1:0]                         prefix_q, prefix_d;
  logic [bbcp_pkg::BitCntWidth-1:0]      bit_cnt_q, bit_cnt_d;
  logic [BW-1:0]                         qprev_q, qprev_d;
  logic [BW-1:0]                         qprefix_q, qprefix_d;
  logic [bbcp_pkg::ProbScaleBits-1:0]    prob_q, prob_d;
  logic                                  out_valid_q, out_valid_d;
  logic [bbcp_pkg::ProbWidth-1:0]        out_prob_q, out_prob_d;

  logic                                  we;
  logic [bbcp_pkg::CtxAddrWidth-1:0]     waddr, raddr;
  logic [bbcp_pkg::RamWidth-1:0]         wdata, rdata;
  logic [CW-1:0]                         zero_cnt, one_cnt;
  logic                                  bit_in;
  bbcp_pkg::div_req_t                    div_req;
  bbcp_pkg::div_rsp_t                    div_rsp;

  bbcp_ram #(
    .Width (bbcp_pkg::RamWidth),
    .Depth (bbcp_pkg::CtxDepth)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bbcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign zero_cnt = rdata[CW-1:0];
  assign one_cnt  = rdata[2*CW-1:CW];
  assign bit_in   = byte_q[BW-1];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    last_d      = last_q;
    byte_d      = byte_q;
    prefix_d    = prefix_q;
    bit_cnt_d   = bit_cnt_q;
    qprev_d     = qprev_q;
    qprefix_d   = qprefix_q;
    prob_d      = prob_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_prob_d  = out_prob_q;

    we    = 1'b0;
    waddr = {last_q, prefix_q};
    wdata = rdata;
    raddr = {qprev_q, qprefix_q};

    div_req.start    = 1'b0;
    div_req.dividend = (CW+1)'(one_cnt) + (CW+1)'(1);
    div_req.divisor  = bbcp_pkg::DivWidth'(zero_cnt) + bbcp_pkg::DivWidth'(one_cnt)
                       + bbcp_pkg::DivWidth'(2);

    in_i.ready = (state_q == bbcp_pkg::ST_IDLE);

    case (state_q)
      bbcp_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + bbcp_pkg::CtxAddrWidth'(1);
        if (clr_q == '1) begin
          state_d = bbcp_pkg::ST_IDLE;
        end
      end
      bbcp_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.action == bbcp_pkg::ACT_QUERY) begin
            qprev_d   = in_i.query_prev;
            qprefix_d = in_i.query_prefix;
            state_d   = bbcp_pkg::ST_QRD;
          end else begin
            byte_d    = in_i.data_byte;
            prefix_d  = BW'(1);
            bit_cnt_d = '0;
            state_d   = bbcp_pkg::ST_LRD;
          end
        end
      end
      bbcp_pkg::ST_LRD: begin
        raddr   = {last_q, prefix_q};
        state_d = bbcp_pkg::ST_LWR;
      end
      bbcp_pkg::ST_LWR: begin
        we = 1'b1;
        if (bit_in) begin
          wdata = {(one_cnt == '1) ? one_cnt : one_cnt + CW'(1), zero_cnt};
        end else begin
          wdata = {one_cnt, (zero_cnt == '1) ? zero_cnt : zero_cnt + CW'(1)};
        end
        byte_d    = {byte_q[BW-2:0], 1'b0};
        prefix_d  = {prefix_q[BW-2:0], bit_in};
        bit_cnt_d = bit_cnt_q + bbcp_pkg::BitCntWidth'(1);
        if (bit_cnt_q == '1) begin
          last_d  = {prefix_q[BW-2:0], bit_in};
          state_d = bbcp_pkg::ST_IDLE;
        end else begin
          state_d = bbcp_pkg::ST_LRD;
        end
      end
      bbcp_pkg::ST_QRD: begin
        state_d = bbcp_pkg::ST_QEVAL;
      end
      bbcp_pkg::ST_QEVAL: begin
        if (qprefix_q == '0 || (zero_cnt == '0 && one_cnt == '0)) begin
          prob_d  = bbcp_pkg::ProbHalf;
          state_d = bbcp_pkg::ST_QOUT;
        end else begin
          div_req.start = 1'b1;
          state_d       = bbcp_pkg::ST_QDIV;
        end
      end
      bbcp_pkg::ST_QDIV: begin
        if (div_rsp.done) begin
          prob_d  = (div_rsp.quotient == '0) ? bbcp_pkg::ProbMin : div_rsp.quotient;
          state_d = bbcp_pkg::ST_QOUT;
        end
      end
      bbcp_pkg::ST_QOUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_prob_d  = bbcp_pkg::ProbWidth'(prob_q);
          state_d     = bbcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bbcp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbcp_pkg::ST_CLEAR;
      clr_q       <= '0;
      last_q      <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      last_q      <= last_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    prefix_q   <= prefix_d;
    qprev_q    <= qprev_d;
    qprefix_q  <= qprefix_d;
    prob_q     <= prob_d;
    out_prob_q <= out_prob_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.probability = out_prob_q;

endmodule
`default_nettype wire

// ===== sim/tb_bigram_bit_context_prior_trainer_unit.sv =====
// Testbench for the bigram bit context trainer: directed and random learn/query traffic against a predictor.
`timescale 1ns / 1ps
module tb_bigram_bit_context_prior_trainer_unit;

  localparam int IdlePct     = 30;
  localparam int FloorLearns = 40;
  localparam int RandItems   = 340;
  localparam int HoldAt      = 40;
  localparam int HoldCycles  = 400;
  localparam int WatchLimit  = 200000;
  localparam int DrainCycles = 40;

  typedef struct {
    bbcp_pkg::action_e              act;
    logic [bbcp_pkg::ByteWidth-1:0] data;
    logic [bbcp_pkg::ByteWidth-1:0] prev;
    logic [bbcp_pkg::ByteWidth-1:0] prefix;
    bit                             sync;
    bit                             calm;
  } bbcp_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bbcp_in_if  in_if ();
  bbcp_out_if out_if ();

  bigram_bit_context_prior_trainer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bbcp_item_t                     pending_q[$];
  logic [bbcp_pkg::ProbWidth-1:0] prob_q[$];

  bit [bbcp_pkg::CountWidth-1:0]  zero_tally [bbcp_pkg::CtxDepth];
  bit [bbcp_pkg::CountWidth-1:0]  one_tally  [bbcp_pkg::CtxDepth];
  logic [bbcp_pkg::ByteWidth-1:0] prev_byte = '0;

  int  err_cnt   = 0;
  int  n_results = 0;
  bit  calm_now  = 1'b0;
  bit  gen_calm  = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void learn_byte(input logic [bbcp_pkg::ByteWidth-1:0] b);
    logic [bbcp_pkg::ByteWidth:0]      pfx;
    logic [bbcp_pkg::CtxAddrWidth-1:0] idx;
    pfx = (bbcp_pkg::ByteWidth+1)'(1);
    for (int k = bbcp_pkg::ByteWidth - 1; k >= 0; k--) begin
      idx = {prev_byte, pfx[bbcp_pkg::ByteWidth-1:0]};
      if (b[k]) begin
        if (one_tally[idx] != '1) one_tally[idx]++;
      end else begin
        if (zero_tally[idx] != '1) zero_tally[idx]++;
      end
      pfx = {pfx[bbcp_pkg::ByteWidth-1:0], b[k]};
    end
    prev_byte = b;
  endfunction

  function automatic logic [bbcp_pkg::ProbWidth-1:0] prob_of(
      input logic [bbcp_pkg::ByteWidth-1:0] prev,
      input logic [bbcp_pkg::ByteWidth-1:0] prefix);
    logic [bbcp_pkg::CtxAddrWidth-1:0] idx;
    longint unsigned                   z;
    longint unsigned                   o;
    longint unsigned                   q;
    idx = {prev, prefix};
    if (prefix == '0) return bbcp_pkg::ProbHalf;
    z = zero_tally[idx];
    o = one_tally[idx];
    if (z + o == 0) return bbcp_pkg::ProbHalf;
    q = ((o + 1) << bbcp_pkg::ProbScaleBits) / (z + o + 2);
    if (q < 1) q = 1;
    else if (q > (64'd1 << bbcp_pkg::ProbScaleBits) - 1)
      q = (64'd1 << bbcp_pkg::ProbScaleBits) - 1;
    return q[bbcp_pkg::ProbWidth-1:0];
  endfunction

  function automatic void add_item(input bbcp_pkg::action_e act,
                                   input logic [bbcp_pkg::ByteWidth-1:0] data,
                                   input logic [bbcp_pkg::ByteWidth-1:0] prev,
                                   input logic [bbcp_pkg::ByteWidth-1:0] prefix,
                                   input bit sync);
    bbcp_item_t it;
    it.act    = act;
    it.data   = data;
    it.prev   = prev;
    it.prefix = prefix;
    it.sync   = sync;
    it.calm   = gen_calm;
    pending_q.push_back(it);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    bbcp_item_t cur;
    bit         take;
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.action       <= bbcp_pkg::ACT_LEARN;
      in_if.data_byte    <= '0;
      in_if.query_prev   <= '0;
      in_if.query_prefix <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (cur.act == bbcp_pkg::ACT_LEARN) learn_byte(cur.data);
        else prob_q.push_back(prob_of(cur.prev, cur.prefix));
        calm_now = cur.calm;
      end
      if (!in_if.valid || in_if.ready) begin
        take = pending_q.size() != 0;
        if (take && pending_q[0].sync && prob_q.size() != 0) take = 1'b0;
        if (take && !pending_q[0].calm && $urandom_range(0, 99) < IdlePct) take = 1'b0;
        if (take) begin
          cur = pending_q.pop_front();
          in_if.action       <= cur.act;
          in_if.data_byte    <= cur.data;
          in_if.query_prev   <= cur.prev;
          in_if.query_prefix <= cur.prefix;
        end
        in_if.valid <= take;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    int                             hold_left;
    bit                             hold_done;
    logic [bbcp_pkg::ProbWidth-1:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (prob_q.size() == 0) begin
          report_mismatch($sformatf("unexpected probability %0d", out_if.probability));
        end else begin
          want = prob_q.pop_front();
          if (out_if.probability !== want)
            report_mismatch($sformatf("probability %0d, want %0d", out_if.probability, want));
        end
      end
      if (!hold_done && n_results >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm_now || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : wdog
    int quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet == WatchLimit) begin
        $display("bigram_bit_context_prior_trainer_unit test failed");
        $finish;
      end
    end
  end

  initial begin : stim
    logic [bbcp_pkg::ByteWidth-1:0] alpha [6];
    logic [bbcp_pkg::ByteWidth-1:0] b;
    int                             k;
    rst_ni = 1'b0;

    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hFF, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'h00, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'hFF, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'hFF, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hFF, 8'hFF, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'hA5, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'h5A, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'h80, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'h01, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_LEARN, 8'h7F, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hFF, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hA5, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h80, 8'h80, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h01, 8'hBF, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hFF, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'hAB, 8'h55, 1'b0);

    // run of zero bytes skews the zero counters toward a low probability
    add_item(bbcp_pkg::ACT_LEARN, 8'h00, 8'h00, 8'h00, 1'b1);
    for (int i = 0; i < FloorLearns; i++)
      add_item(bbcp_pkg::ACT_LEARN, 8'h00, 8'h00, 8'h00, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h01, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h80, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h10, 1'b0);
    add_item(bbcp_pkg::ACT_QUERY, 8'h00, 8'h00, 8'h03, 1'b0);

    for (int i = 0; i < 6; i++) alpha[i] = bbcp_pkg::ByteWidth'($urandom_range(0, 255));
    for (int i = 0; i < RandItems; i++) begin
      gen_calm = (i >= 150 && i < 250);
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 99) < 80) b = alpha[$urandom_range(0, 5)];
        else b = bbcp_pkg::ByteWidth'($urandom_range(0, 255));
        add_item(bbcp_pkg::ACT_LEARN, b, bbcp_pkg::ByteWidth'($urandom_range(0, 255)),
                 bbcp_pkg::ByteWidth'($urandom_range(0, 255)), i == 100 || i == 300);
      end else if ($urandom_range(0, 99) < 75) begin
        b = alpha[$urandom_range(0, 5)];
        k = $urandom_range(0, 7);
        add_item(bbcp_pkg::ACT_QUERY, bbcp_pkg::ByteWidth'($urandom_range(0, 255)),
                 alpha[$urandom_range(0, 5)],
                 bbcp_pkg::ByteWidth'((9'd1 << k) | (9'(b) >> (bbcp_pkg::ByteWidth - k))),
                 i == 100 || i == 300);
      end else begin
        add_item(bbcp_pkg::ACT_QUERY, bbcp_pkg::ByteWidth'($urandom_range(0, 255)),
                 bbcp_pkg::ByteWidth'($urandom_range(0, 255)),
                 bbcp_pkg::ByteWidth'($urandom_range(0, 255)), i == 100 || i == 300);
      end
    end
    gen_calm = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (prob_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("bigram_bit_context_prior_trainer_unit test passed");
    end else begin
      $display("bigram_bit_context_prior_trainer_unit test failed");
    end
    $finish;
  end

endmodule
